### src/crm_pkg.sv
// Package for the color-to-depth inverse remap block.
// Holds frame constants, transaction types, item kind codes and address helpers.
// Used by every module of the block but crm_ram; depends on nothing else.
package crm_pkg;

	localparam int COLOR_WIDTH  = 640;
	localparam int COLOR_HEIGHT = 480;
	localparam int DEPTH_WIDTH  = 640;
	localparam int DEPTH_HEIGHT = 480;

	localparam int MAP_CELLS   = COLOR_WIDTH * COLOR_HEIGHT;
	localparam int STORE_CELLS = DEPTH_WIDTH * DEPTH_HEIGHT;
	localparam int MAP_AW      = $clog2(MAP_CELLS);
	localparam int DEPTH_AW    = $clog2(STORE_CELLS);
	localparam int MAP_DW      = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_FWD   = 2'd1;
	localparam logic [1:0] KIND_DEPTH = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [9:0]         depth_col;
		logic [8:0]         depth_row;
		logic signed [11:0] color_col;
		logic signed [11:0] color_row;
		logic [15:0]        depth_sample;
		logic               last_in_batch;
	} item_t;

	typedef struct packed {
		logic        found;
		logic        from_neighbors;
		logic [13:0] result_col_fx;
		logic [12:0] result_row_fx;
		logic [15:0] result_depth;
		logic        last_of_batch;
	} result_t;

	typedef struct packed {
		item_t                item;
		logic                 color_ok;
		logic                 depth_ok;
		logic [MAP_AW-1:0]    map_addr;
		logic [DEPTH_AW-1:0]  depth_addr;
	} cmd_t;

	function automatic logic color_inside(logic signed [12:0] c, logic signed [12:0] r);
		return (c >= 13'sd0) && (int'(c) < COLOR_WIDTH) &&
		       (r >= 13'sd0) && (int'(r) < COLOR_HEIGHT);
	endfunction

	function automatic logic [MAP_AW-1:0] map_index(logic [10:0] c, logic [10:0] r);
		return MAP_AW'(int'(r) * COLOR_WIDTH + int'(c));
	endfunction

	function automatic logic [DEPTH_AW-1:0] depth_index(logic [10:0] c, logic [9:0] r);
		return DEPTH_AW'(int'(r) * DEPTH_WIDTH + int'(c));
	endfunction

endpackage

### src/color_to_depth_inverse_remap.sv
// Top level of the color-to-depth inverse remap block.
// Connects the front end (crm_front) and the back end (crm_back); uses crm_pkg.
//
// Forward-map and depth-sample transactions are taken one per clock while the
// command queue has room. A query holds the back end from the cycle it leaves the
// queue to the cycle its result is loaded: when it falls back on neighbor
// averaging, for the nine neighbor map reads, the 17-step bit-serial divide and
// then the depth read; when no neighbor is valid, for the nine neighbor map reads
// only; on a direct hit, for the center map read and the depth read. The single
// read port of the map memory and the divider shape these paths, and a stalled
// result holds the back end longer. A clear transaction, and reset, start a
// sweep that writes every cell of the map memory (COLOR_WIDTH*COLOR_HEIGHT cells,
// 307200 at 640x480); after reset no input transaction is taken until that sweep
// ends, and after a clear the queue fills and then stalls until it ends.
module color_to_depth_inverse_remap import crm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	cmd_t head;
	logic head_valid;
	logic pop;
	logic hold;

	crm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.hold       (hold),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	crm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.hold         (hold),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

### src/crm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no other dependencies.
module crm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/crm_front.sv
// Front end: accepts input transactions, checks frame bounds, forms addresses
// and holds the results in a short command queue. Depends on crm_pkg.
module crm_front import crm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  item_valid,
	output logic  item_stall,
	input  logic  hold,
	input  logic  pop,
	output cmd_t  head,
	output logic  head_valid
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                push;
	cmd_t                cmd;

	assign item_stall = (int'(count_q) == QUEUE_DEPTH) || hold;
	assign push       = item_valid && !item_stall;
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);

	always_comb begin
		cmd.item       = item;
		cmd.color_ok   = color_inside({item.color_col[11], item.color_col},
		                              {item.color_row[11], item.color_row});
		cmd.depth_ok   = (int'(item.depth_col) < DEPTH_WIDTH) &&
		                 (int'(item.depth_row) < DEPTH_HEIGHT);
		cmd.map_addr   = map_index(item.color_col[10:0], item.color_row[10:0]);
		cmd.depth_addr = depth_index({1'b0, item.depth_col}, {1'b0, item.depth_row});
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/crm_div.sv
// Restoring divider, one quotient bit per cycle, for the neighbor averages.
// Divides a 17-bit numerator by a 4-bit count. Depends on crm_pkg.
module crm_div import crm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] num,
	input  logic [3:0]  den,
	output logic [16:0] quot,
	output logic        done
);

	logic [16:0] num_q;
	logic [16:0] quot_q;
	logic [3:0]  rem_q;
	logic [3:0]  den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  shifted;
	logic        ge;
	logic [4:0]  diff;

	assign shifted = {rem_q, num_q[16]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};
	assign quot    = quot_q;
	assign done    = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[15:0], 1'b0};
			rem_q  <= ge ? diff[3:0] : shifted[3:0];
			quot_q <= {quot_q[15:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### src/crm_back.sv
// Back end: runs commands from the queue against the inverse map and depth store,
// clears the map, resolves queries and holds the result register.
// Depends on crm_pkg, crm_ram and crm_div.
module crm_back import crm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head,
	input  logic    head_valid,
	output logic    pop,
	output logic    hold,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CENTER = 3'd2;
	localparam logic [2:0] S_NB     = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_DREAD  = 3'd5;
	localparam logic [2:0] S_DWAIT  = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]          state_q;
	logic                init_q;
	logic [MAP_AW-1:0]   clr_cnt_q;
	logic signed [11:0]  qcol_q;
	logic signed [11:0]  qrow_q;
	logic                qlast_q;
	logic                qok_q;
	logic [3:0]          nb_cnt_q;
	logic                nb_ins_q;
	logic [3:0]          n_q;
	logic [12:0]         sc_q;
	logic [12:0]         sr_q;
	logic [13:0]         colfx_q;
	logic [12:0]         rowfx_q;
	logic                found_q;
	logic                nbflag_q;
	logic                dok_q;
	logic [15:0]         depth_q;
	result_t             res_q;
	logic                res_valid_q;

	logic                map_we;
	logic [MAP_AW-1:0]   map_waddr;
	logic [MAP_DW-1:0]   map_wdata;
	logic [MAP_AW-1:0]   map_raddr;
	logic [MAP_DW-1:0]   map_rdata;
	logic                dep_we;
	logic [DEPTH_AW-1:0] dep_raddr;
	logic [15:0]         dep_rdata;

	logic signed [12:0]  dx;
	logic signed [12:0]  dy;
	logic signed [12:0]  nc;
	logic signed [12:0]  nr;
	logic                n_inside;
	logic                acc_hit;
	logic [3:0]          n_nx;
	logic [12:0]         sc_nx;
	logic [12:0]         sr_nx;
	logic                div_start;
	logic [16:0]         num_c;
	logic [16:0]         num_r;
	logic [16:0]         quot_c;
	logic [16:0]         quot_r;
	logic                done_c;
	logic                done_r;
	logic [14:0]         rc_sum;
	logic [13:0]         rr_sum;
	logic [10:0]         rc;
	logic [9:0]          rr;
	logic                load;

	assign hold = init_q;
	assign pop  = (state_q == S_IDLE) && head_valid;

	always_comb begin
		case (nb_cnt_q)
			4'd0, 4'd1, 4'd2: dy = -13'sd1;
			4'd3, 4'd4, 4'd5: dy = 13'sd0;
			default:          dy = 13'sd1;
		endcase
		case (nb_cnt_q)
			4'd0, 4'd3, 4'd6: dx = -13'sd1;
			4'd1, 4'd4, 4'd7: dx = 13'sd0;
			default:          dx = 13'sd1;
		endcase
	end

	assign nc       = {qcol_q[11], qcol_q} + dx;
	assign nr       = {qrow_q[11], qrow_q} + dy;
	assign n_inside = color_inside(nc, nr);
	assign acc_hit  = (nb_cnt_q != 4'd0) && nb_ins_q && map_rdata[MAP_DW-1];
	assign n_nx     = n_q + {3'd0, acc_hit};
	assign sc_nx    = sc_q + (acc_hit ? {3'd0, map_rdata[18:9]} : 13'd0);
	assign sr_nx    = sr_q + (acc_hit ? {4'd0, map_rdata[8:0]} : 13'd0);
	assign num_c    = {sc_nx, 4'd0} + {14'd0, n_nx[3:1]};
	assign num_r    = {sr_nx, 4'd0} + {14'd0, n_nx[3:1]};
	assign div_start = (state_q == S_NB) && (nb_cnt_q == 4'd9) && (n_nx != 4'd0);

	assign rc_sum = {1'b0, colfx_q} + 15'd8;
	assign rr_sum = {1'b0, rowfx_q} + 14'd8;
	assign rc     = rc_sum[14:4];
	assign rr     = rr_sum[13:4];

	always_comb begin
		map_we    = 1'b0;
		map_waddr = head.map_addr;
		map_wdata = {1'b1, head.item.depth_col, head.item.depth_row};
		map_raddr = head.map_addr;
		dep_we    = 1'b0;
		dep_raddr = depth_index(rc, rr);
		case (state_q)
			S_CLR: begin
				map_we    = 1'b1;
				map_waddr = clr_cnt_q;
				map_wdata = '0;
			end
			S_IDLE: begin
				map_we = pop && (head.item.kind == KIND_FWD) &&
				         head.color_ok && head.depth_ok;
				dep_we = pop && (head.item.kind == KIND_DEPTH) && head.depth_ok;
			end
			S_NB: begin
				map_raddr = map_index(nc[10:0], nr[10:0]);
			end
			default: begin
			end
		endcase
	end

	assign load = (state_q == S_OUT) && (!res_valid_q || !result_stall);

	crm_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_CELLS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	crm_ram #(.WIDTH(16), .DEPTH(STORE_CELLS)) u_depth (
		.clk   (clk),
		.we    (dep_we),
		.waddr (head.depth_addr),
		.wdata (head.item.depth_sample),
		.raddr (dep_raddr),
		.rdata (dep_rdata)
	);

	crm_div u_div_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c),
		.den    (n_nx),
		.quot   (quot_c),
		.done   (done_c)
	);

	crm_div u_div_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_r),
		.den    (n_nx),
		.quot   (quot_r),
		.done   (done_r)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				qcol_q  <= head.item.color_col;
				qrow_q  <= head.item.color_row;
				qlast_q <= head.item.last_in_batch;
				qok_q   <= head.color_ok;
			end
			S_CENTER: begin
				nb_cnt_q <= '0;
				n_q      <= '0;
				sc_q     <= '0;
				sr_q     <= '0;
				nb_ins_q <= 1'b0;
				found_q  <= 1'b1;
				nbflag_q <= 1'b0;
				colfx_q  <= {map_rdata[18:9], 4'd0};
				rowfx_q  <= {map_rdata[8:0], 4'd0};
			end
			S_NB: begin
				nb_cnt_q <= nb_cnt_q + 1'b1;
				nb_ins_q <= n_inside;
				n_q      <= n_nx;
				sc_q     <= sc_nx;
				sr_q     <= sr_nx;
				if ((nb_cnt_q == 4'd9) && (n_nx == 4'd0)) begin
					found_q  <= 1'b0;
					nbflag_q <= 1'b0;
					colfx_q  <= '0;
					rowfx_q  <= '0;
					depth_q  <= '0;
				end
			end
			S_DIV: begin
				if (done_c) begin
					found_q  <= 1'b1;
					nbflag_q <= 1'b1;
					colfx_q  <= quot_c[13:0];
					rowfx_q  <= quot_r[12:0];
				end
			end
			S_DREAD: begin
				dok_q <= (int'(rc) < DEPTH_WIDTH) && (int'(rr) < DEPTH_HEIGHT);
			end
			S_DWAIT: begin
				depth_q <= dok_q ? dep_rdata : 16'd0;
			end
			default: begin
			end
		endcase
		if (load) begin
			res_q.found          <= found_q;
			res_q.from_neighbors <= nbflag_q;
			res_q.result_col_fx  <= colfx_q;
			res_q.result_row_fx  <= rowfx_q;
			res_q.result_depth   <= depth_q;
			res_q.last_of_batch  <= qlast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			init_q      <= 1'b1;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (int'(clr_cnt_q) == MAP_CELLS - 1) begin
						clr_cnt_q <= '0;
						init_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop && (head.item.kind == KIND_CLEAR)) begin
						state_q <= S_CLR;
					end else if (pop && (head.item.kind == KIND_QUERY)) begin
						state_q <= S_CENTER;
					end
				end
				S_CENTER: begin
					state_q <= (qok_q && map_rdata[MAP_DW-1]) ? S_DREAD : S_NB;
				end
				S_NB: begin
					if (nb_cnt_q == 4'd9) begin
						state_q <= (n_nx != 4'd0) ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (done_c) begin
						state_q <= S_DREAD;
					end
				end
				S_DREAD: state_q <= S_DWAIT;
				S_DWAIT: state_q <= S_OUT;
				S_OUT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !pop) else $error("command taken during map sweep");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (n_nx != 4'd0)) else $error("average started with no neighbors");

	a_dividers_agree: assert property (@(posedge clk) disable iff (!arst_n)
		done_c == done_r) else $error("column and row dividers out of step");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!res_valid_q || !result_stall)) else $error("result overwritten");

endmodule

### dv/color_to_depth_inverse_remap_tb.sv
// Testbench for color_to_depth_inverse_remap: a directed table, then random transactions.
// Expected results come from typed rows or a predictor of inverse map and depth store.
// Depends on crm_pkg and the color_to_depth_inverse_remap RTL.
`timescale 1ns / 1ps

module color_to_depth_inverse_remap_tb;
	import crm_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES  = 200;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;

	logic [19:0] map_model [int];
	logic [15:0] depth_model [int];
	result_t     pending_results [$];
	int          errors;
	int          sent_count;
	int          query_count;
	int          hit_count;
	int          neighbor_count;
	int          idle_cycles;
	bit          quiet;
	bit          hold_request;

	color_to_depth_inverse_remap DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit map_inside(int c, int r);
		return c >= 0 && c < COLOR_WIDTH && r >= 0 && r < COLOR_HEIGHT;
	endfunction

	function automatic result_t lookup_depth(item_t it, output int daddr);
		result_t     res;
		logic [19:0] e;
		int          c;
		int          r;
		int          n;
		int          sc;
		int          sr;
		int          cf;
		int          rf;
		int          rc;
		int          rr;
		res = '0;
		daddr = -1;
		c = it.color_col;
		r = it.color_row;
		n = 0;
		sc = 0;
		sr = 0;
		cf = 0;
		rf = 0;
		e = '0;
		if (map_inside(c, r) && map_model.exists(r * COLOR_WIDTH + c))
			e = map_model[r * COLOR_WIDTH + c];
		if (e[19]) begin
			res.found = 1'b1;
			cf = int'(e[18:9]) * 16;
			rf = int'(e[8:0]) * 16;
		end else begin
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					if (map_inside(c + dx, r + dy) &&
					    map_model.exists((r + dy) * COLOR_WIDTH + c + dx)) begin
						e = map_model[(r + dy) * COLOR_WIDTH + c + dx];
						sc += e[18:9];
						sr += e[8:0];
						n++;
					end
				end
			end
			if (n > 0) begin
				res.found = 1'b1;
				res.from_neighbors = 1'b1;
				cf = (sc * 16 + n / 2) / n;
				rf = (sr * 16 + n / 2) / n;
			end
		end
		if (res.found) begin
			rc = (cf + 8) >> 4;
			rr = (rf + 8) >> 4;
			if (rc < DEPTH_WIDTH && rr < DEPTH_HEIGHT) begin
				daddr = rr * DEPTH_WIDTH + rc;
				if (depth_model.exists(daddr))
					res.result_depth = depth_model[daddr];
			end
		end
		res.result_col_fx = cf[13:0];
		res.result_row_fx = rf[12:0];
		res.last_of_batch = it.last_in_batch;
		return res;
	endfunction

	task automatic drive_item(item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3) - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sent_count++;
	endtask

	task automatic send_item(item_t it, bit typed, result_t typed_res);
		result_t res;
		item_t   fill;
		int      daddr;
		case (it.kind)
			KIND_CLEAR: map_model.delete();
			KIND_FWD: begin
				if (map_inside(it.color_col, it.color_row) && it.depth_col < DEPTH_WIDTH &&
				    it.depth_row < DEPTH_HEIGHT)
					map_model[it.color_row * COLOR_WIDTH + it.color_col] =
						{1'b1, it.depth_col, it.depth_row};
			end
			KIND_DEPTH: begin
				if (it.depth_col < DEPTH_WIDTH && it.depth_row < DEPTH_HEIGHT)
					depth_model[it.depth_row * DEPTH_WIDTH + it.depth_col] = it.depth_sample;
			end
			default: begin
				res = lookup_depth(it, daddr);
				if (daddr >= 0 && !depth_model.exists(daddr)) begin
					fill = '0;
					fill.kind = KIND_DEPTH;
					fill.depth_col = 10'(daddr % DEPTH_WIDTH);
					fill.depth_row = 9'(daddr / DEPTH_WIDTH);
					fill.depth_sample = 16'($urandom);
					depth_model[daddr] = fill.depth_sample;
					drive_item(fill);
					res = lookup_depth(it, daddr);
				end
				query_count++;
				if (res.found && res.from_neighbors)
					neighbor_count++;
				else if (res.found)
					hit_count++;
				pending_results.push_back(typed ? typed_res : res);
			end
		endcase
		drive_item(it);
	endtask

	function automatic item_t make_item(logic [1:0] kind, int dc, int dr, int cc, int cr,
	                                    int smp, bit last);
		item_t it;
		it.kind = kind;
		it.depth_col = 10'(dc);
		it.depth_row = 9'(dr);
		it.color_col = 12'(cc);
		it.color_row = 12'(cr);
		it.depth_sample = 16'(smp);
		it.last_in_batch = last;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    pick;
		int    bc;
		int    br;
		pick = $urandom_range(0, 2);
		bc = (pick == 0) ? 0 : (pick == 1) ? COLOR_WIDTH - 12 : 300;
		br = (pick == 0) ? 0 : (pick == 1) ? COLOR_HEIGHT - 12 : 200;
		it = make_item(KIND_FWD, $urandom_range(0, DEPTH_WIDTH - 1),
		               $urandom_range(0, DEPTH_HEIGHT - 1), bc + $urandom_range(0, 11),
		               br + $urandom_range(0, 11), $urandom, $urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.kind = KIND_QUERY;
			it.color_col = 12'(bc - 1 + $urandom_range(0, 13));
			it.color_row = 12'(br - 1 + $urandom_range(0, 13));
		end else if (pick < 55) begin
			it.kind = KIND_DEPTH;
		end else if (pick < 65) begin
			it = 62'($urandom) | (62'($urandom) << 32);
			if (it.kind == KIND_CLEAR)
				it.kind = KIND_QUERY;
		end
		return it;
	endfunction

	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no query waiting");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, result.found);
					errors++;
				end
				if (result.from_neighbors !== want.from_neighbors) begin
					$error("from_neighbors: expected %0d, actual %0d",
					       want.from_neighbors, result.from_neighbors);
					errors++;
				end
				if (result.result_col_fx !== want.result_col_fx) begin
					$error("result_col_fx: expected %0d, actual %0d",
					       want.result_col_fx, result.result_col_fx);
					errors++;
				end
				if (result.result_row_fx !== want.result_row_fx) begin
					$error("result_row_fx: expected %0d, actual %0d",
					       want.result_row_fx, result.result_row_fx);
					errors++;
				end
				if (result.result_depth !== want.result_depth) begin
					$error("result_depth: expected %0d, actual %0d",
					       want.result_depth, result.result_depth);
					errors++;
				end
				if (result.last_of_batch !== want.last_of_batch) begin
					$error("last_of_batch: expected %0d, actual %0d",
					       want.last_of_batch, result.last_of_batch);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		row_t    rows [$];
		result_t none;
		result_t none_last;
		none = '0;
		none_last = '0;
		none_last.last_of_batch = 1'b1;
		errors = 0;
		sent_count = 0;
		query_count = 0;
		hit_count = 0;
		neighbor_count = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		item = '0;
		item_valid = 1'b0;
		rows = '{
			'{make_item(KIND_QUERY, 0, 0, 5, 5, 0, 1), 1, none_last},
			'{make_item(KIND_QUERY, 0, 0, -2048, -2048, 0, 0), 1, none},
			'{make_item(KIND_QUERY, 1023, 511, 2047, 2047, 65535, 0), 1, none},
			'{make_item(KIND_FWD, 639, 479, 0, 0, 0, 0), 0, none},
			'{make_item(KIND_FWD, 0, 0, 639, 479, 0, 0), 0, none},
			'{make_item(KIND_FWD, 5, 5, 640, 0, 0, 0), 0, none},
			'{make_item(KIND_FWD, 1023, 511, 1, 1, 0, 0), 0, none},
			'{make_item(KIND_DEPTH, 639, 479, 0, 0, 65535, 0), 0, none},
			'{make_item(KIND_DEPTH, 0, 0, 0, 0, 0, 0), 0, none},
			'{make_item(KIND_DEPTH, 1023, 511, 0, 0, 1234, 0), 0, none},
			'{make_item(KIND_QUERY, 0, 0, 0, 0, 0, 0), 0, none},
			'{make_item(KIND_QUERY, 0, 0, 639, 479, 0, 1), 0, none},
			'{make_item(KIND_QUERY, 0, 0, 1, 0, 0, 0), 0, none},
			'{make_item(KIND_QUERY, 0, 0, -1, -1, 0, 0), 0, none},
			'{make_item(KIND_QUERY, 0, 0, 640, 480, 0, 1), 0, none},
			'{make_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, none},
			'{make_item(KIND_QUERY, 0, 0, 0, 0, 0, 1), 1, none_last}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i])
			send_item(rows[i].it, rows[i].typed, rows[i].res);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300)
				hold_request = 1'b1;
			if (i == RANDOM_ITEMS - 100)
				quiet = 1'b1;
			if (i == 400)
				send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, none);
			else
				send_item(random_item(), 0, none);
		end
		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d transactions with %0d queries: %0d direct hits, %0d averaged.",
		         sent_count, query_count, hit_count, neighbor_count);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
